@@ rtl/scs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants and types for the strided cumulative sum block.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int DATA_WIDTH   = 64;
    localparam int SUM_WIDTH    = 64;
    localparam int MAX_STRIDE   = 1024;
    localparam int ADDR_WIDTH   = $clog2(MAX_STRIDE);
    localparam int RUN_WIDTH    = 17;
    localparam int STRIDE_WIDTH = 11;
    localparam int GROUP_WIDTH  = 25;
    localparam int AXIS_WIDTH   = 16;
    localparam int GPOS_WIDTH   = 24;
    localparam int CFG_WIDTH    = 25;
    localparam int IDX_WIDTH    = 2;

    localparam logic [RUN_WIDTH-1:0]    RUN_MAX    = RUN_WIDTH'(65536);
    localparam logic [STRIDE_WIDTH-1:0] STRIDE_MAX = STRIDE_WIDTH'(MAX_STRIDE);
    localparam logic [GROUP_WIDTH-1:0]  GROUP_MAX  = GROUP_WIDTH'(16777216);

    typedef enum logic [IDX_WIDTH-1:0] {
        CFG_RUN_LENGTH  = 2'd0,
        CFG_STRIDE      = 2'd1,
        CFG_GROUP_COUNT = 2'd2
    } scs_cfg_idx_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_WIDTH-1:0] addr;
        logic [DATA_WIDTH-1:0] data;
    } scs_wr_t;

endpackage
`default_nettype wire

@@ rtl/scs_line_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scs_line_store
// Running-sum line store: registered read, one write port, and a
// bypass for a write landing on the entry read in the same cycle.
// ----------------------------------------------------------------------------
module scs_line_store
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [scs_pkg::ADDR_WIDTH-1:0] rd_addr,
    input  wire scs_pkg::scs_wr_t              wr,
    output logic      [scs_pkg::DATA_WIDTH-1:0] rd_data
);
    import scs_pkg::*;

    logic [DATA_WIDTH-1:0] mem [MAX_STRIDE];
    logic [DATA_WIDTH-1:0] rd_q_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;
    logic                  fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule
`default_nettype wire

@@ rtl/strided_cumulative_sum_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strided_cumulative_sum_top
// Running sum along one axis of a row-major tensor using a stride-deep line
// store of partial sums.
// ----------------------------------------------------------------------------
// Takes one element per cycle while the output is not stalled, for any
// stride including 1. The line store is read when an element is accepted,
// and the add, the write-back and the load of the output register happen
// when the read stage advances. The block holds two elements; the input
// stalls while the output register holds a stalled beat and the read stage
// is occupied. Back-to-back hits on the same entry are served by a bypass
// in the line store. Any configuration write restarts the tensor.
module strided_cumulative_sum_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [scs_pkg::IDX_WIDTH-1:0] cfg_index,
    input  wire logic        [scs_pkg::CFG_WIDTH-1:0] cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic signed [63:0]                  value,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed      [63:0]                  sum,
    output logic                                     last_of_tensor
);
    import scs_pkg::*;

    logic [AXIS_WIDTH-1:0]   run_last_reg;
    logic [ADDR_WIDTH-1:0]   str_last_reg;
    logic [GPOS_WIDTH-1:0]   grp_last_reg;
    logic [ADDR_WIDTH-1:0]   inner_reg;
    logic [AXIS_WIDTH-1:0]   axis_reg;
    logic [GPOS_WIDTH-1:0]   group_reg;

    logic                    s1_valid_reg;
    logic [DATA_WIDTH-1:0]   s1_value_reg;
    logic [ADDR_WIDTH-1:0]   s1_addr_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;

    logic                    out_valid_reg;
    logic signed [SUM_WIDTH-1:0] out_sum_reg;
    logic                    out_last_reg;

    logic                    cfg_we;
    logic                    accept;
    logic                    s1_advance;
    logic                    inner_end;
    logic                    axis_end;
    logic                    group_end;
    logic                    item_last;
    logic [DATA_WIDTH-1:0]   rd_data;
    logic signed [DATA_WIDTH-1:0] sum_next;
    scs_wr_t                 wr;

    logic [RUN_WIDTH-1:0]    run_raw;
    logic [STRIDE_WIDTH-1:0] str_raw;
    logic [GROUP_WIDTH-1:0]  grp_raw;
    logic [AXIS_WIDTH-1:0]   run_last_next;
    logic [ADDR_WIDTH-1:0]   str_last_next;
    logic [GPOS_WIDTH-1:0]   grp_last_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // config: store effective value minus one
    assign run_raw = cfg_data[RUN_WIDTH-1:0];
    assign str_raw = cfg_data[STRIDE_WIDTH-1:0];
    assign grp_raw = cfg_data[GROUP_WIDTH-1:0];

    always_comb
    begin
        run_last_next = '0;
        str_last_next = '0;
        grp_last_next = '0;
        if (run_raw > RUN_MAX)
            run_last_next = AXIS_WIDTH'(RUN_MAX - RUN_WIDTH'(1));
        else if (run_raw != '0)
            run_last_next = AXIS_WIDTH'(run_raw - RUN_WIDTH'(1));
        if (str_raw > STRIDE_MAX)
            str_last_next = ADDR_WIDTH'(STRIDE_MAX - STRIDE_WIDTH'(1));
        else if (str_raw != '0)
            str_last_next = ADDR_WIDTH'(str_raw - STRIDE_WIDTH'(1));
        if (grp_raw > GROUP_MAX)
            grp_last_next = GPOS_WIDTH'(GROUP_MAX - GROUP_WIDTH'(1));
        else if (grp_raw != '0)
            grp_last_next = GPOS_WIDTH'(grp_raw - GROUP_WIDTH'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_last_reg <= '0;
            str_last_reg <= '0;
            grp_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RUN_LENGTH:  run_last_reg <= run_last_next;
                CFG_STRIDE:      str_last_reg <= str_last_next;
                CFG_GROUP_COUNT: grp_last_reg <= grp_last_next;
                default:         ;
            endcase
        end
    end

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_advance;
    assign accept     = item_valid && !item_stall;

    // position counters
    assign inner_end = (inner_reg == str_last_reg);
    assign axis_end  = (axis_reg == run_last_reg);
    assign group_end = (group_reg == grp_last_reg);
    assign item_last = inner_end && axis_end && group_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            axis_reg  <= '0;
            group_reg <= '0;
        end
        else if (cfg_we || (accept && item_last))
        begin
            inner_reg <= '0;
            axis_reg  <= '0;
            group_reg <= '0;
        end
        else if (accept)
        begin
            if (!inner_end)
            begin
                inner_reg <= inner_reg + ADDR_WIDTH'(1);
            end
            else
            begin
                inner_reg <= '0;
                if (!axis_end)
                begin
                    axis_reg <= axis_reg + AXIS_WIDTH'(1);
                end
                else
                begin
                    axis_reg  <= '0;
                    group_reg <= group_reg + GPOS_WIDTH'(1);
                end
            end
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= value[DATA_WIDTH-1:0];
            s1_addr_reg  <= inner_reg;
            s1_first_reg <= (axis_reg == '0);
            s1_last_reg  <= item_last;
        end
    end

    scs_line_store u_line_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (inner_reg),
        .wr      (wr),
        .rd_data (rd_data)
    );

    // add and write back
    assign sum_next = s1_first_reg ? s1_value_reg : s1_value_reg + rd_data;

    assign wr.en   = s1_advance;
    assign wr.addr = s1_addr_reg;
    assign wr.data = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sum_reg  <= SUM_WIDTH'(sum_next);
            out_last_reg <= s1_last_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign sum            = out_sum_reg;
    assign last_of_tensor = out_last_reg;

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for strided_cumulative_sum_top. A queue-fed driver
// streams tensor elements while a shadow model of the line store and the
// position counters predicts each running sum and end-of-tensor flag. The
// predictions are compared beat by beat against the output channel under
// several idle/stall mixes, register extremes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam logic [IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] sum;
        logic        last;
    } cumsum_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_WIDTH-1:0]    cfg_index;
    logic [CFG_WIDTH-1:0]    cfg_data;
    logic                    item_valid;
    logic                    item_stall;
    logic signed [63:0]      value;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [63:0]      sum;
    logic                    last_of_tensor;

    logic [63:0]             pending_values[$];
    cumsum_t                 expected_sums[$];

    logic [RUN_WIDTH-1:0]    run_reg;
    logic [STRIDE_WIDTH-1:0] stride_reg;
    logic [GROUP_WIDTH-1:0]  group_reg;
    logic [63:0]             line_sums[MAX_STRIDE];
    int unsigned             inner_pos;
    int unsigned             axis_pos;
    int unsigned             group_pos;

    int                      idle_pct;
    int                      stall_pct;
    int                      hold_cycles;
    int                      mismatches;
    int                      random_items;

    strided_cumulative_sum_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .value          (value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sum            (sum),
        .last_of_tensor (last_of_tensor)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int unsigned clamp_reg(input int unsigned raw, input int unsigned cap);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > cap)
        begin
            return cap;
        end
        return raw;
    endfunction

    task automatic predict_sum(input logic [63:0] v);
        int unsigned run_len;
        int unsigned str;
        int unsigned grp;
        cumsum_t     beat;
        run_len = clamp_reg(run_reg, RUN_MAX);
        str     = clamp_reg(stride_reg, STRIDE_MAX);
        grp     = clamp_reg(group_reg, GROUP_MAX);
        if (axis_pos == 0)
        begin
            beat.sum = v;
        end
        else
        begin
            beat.sum = v + line_sums[inner_pos];
        end
        line_sums[inner_pos] = beat.sum;
        beat.last = (inner_pos + 1 >= str) && (axis_pos + 1 >= run_len)
                    && (group_pos + 1 >= grp);
        if (beat.last)
        begin
            inner_pos = 0;
            axis_pos  = 0;
            group_pos = 0;
        end
        else if (inner_pos + 1 < str)
        begin
            inner_pos = inner_pos + 1;
        end
        else
        begin
            inner_pos = 0;
            if (axis_pos + 1 < run_len)
            begin
                axis_pos = axis_pos + 1;
            end
            else
            begin
                axis_pos  = 0;
                group_pos = group_pos + 1;
            end
        end
        expected_sums.push_back(beat);
    endtask

    // input side: register writes and accepted elements feed the shadow model
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RUN_LENGTH:  run_reg    = cfg_data[RUN_WIDTH-1:0];
                    CFG_STRIDE:      stride_reg = cfg_data[STRIDE_WIDTH-1:0];
                    CFG_GROUP_COUNT: group_reg  = cfg_data[GROUP_WIDTH-1:0];
                    default:         ;
                endcase
                inner_pos = 0;
                axis_pos  = 0;
                group_pos = 0;
            end
            if (item_valid && !item_stall)
            begin
                predict_sum(value);
            end
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item_valid <= 1'b1;
                value      <= pending_values.pop_front();
            end
            else
            begin
                item_valid <= 1'b0;
                value      <= {$urandom, $urandom};
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles  = hold_cycles - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cumsum_t beat;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected beat: sum=%h last=%b", sum, last_of_tensor);
                end
            end
            else
            begin
                beat = expected_sums.pop_front();
                if (sum !== beat.sum || last_of_tensor !== beat.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: sum exp=%h got=%h, last exp=%b got=%b",
                                 beat.sum, sum, beat.last, last_of_tensor);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [RUN_WIDTH-1:0] r, input logic [STRIDE_WIDTH-1:0] s,
                                input logic [GROUP_WIDTH-1:0] g);
        logic [CFG_WIDTH-1:0] junk;
        junk = CFG_WIDTH'($urandom);
        write_reg(CFG_RUN_LENGTH, {junk[CFG_WIDTH-1:RUN_WIDTH], r});
        junk = CFG_WIDTH'($urandom);
        write_reg(CFG_STRIDE, {junk[CFG_WIDTH-1:STRIDE_WIDTH], s});
        write_reg(CFG_GROUP_COUNT, g);
        if ($urandom_range(2) == 0)
        begin
            write_reg(CFG_UNUSED, CFG_WIDTH'($urandom));
        end
        @(negedge clk);
    endtask

    task automatic settle();
        do @(posedge clk);
        while (pending_values.size() != 0 || item_valid || expected_sums.size() != 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            1:       begin idle_pct = 66; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 66; end
            3:       begin idle_pct = 28; stall_pct = 28; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0:       return MAX_POS - $urandom_range(3);
            1:       return MIN_NEG + $urandom_range(3);
            2:       return 64'($signed($urandom_range(200)) - 100);
            3:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_values.push_back(pick_value());
    endtask

    initial
    begin
        int unsigned r;
        int unsigned s;
        int unsigned g;
        int unsigned tensor;
        int          n;
        int          phase;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_RUN_LENGTH;
        cfg_data     = '0;
        item_valid   = 1'b0;
        value        = '0;
        result_stall = 1'b0;
        run_reg      = 1;
        stride_reg   = 1;
        group_reg    = 1;
        inner_pos    = 0;
        axis_pos     = 0;
        group_pos    = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        mismatches   = 0;
        random_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: each element is a tensor of its own
        pending_values = '{64'd0, MAX_POS, MIN_NEG, ALL_ONES};
        settle();
        apply_config(3, 2, 1);
        pending_values = '{MAX_POS, MIN_NEG, MAX_POS, 64'd1, MAX_POS, MIN_NEG};
        settle();
        // out-of-list write restarts a tensor midway
        apply_config(3, 2, 2);
        pending_values = '{64'd5, MAX_POS, 64'd7};
        settle();
        write_reg(CFG_UNUSED, CFG_WIDTH'($urandom));
        @(negedge clk);
        pending_values = '{MAX_POS, 64'd1, 64'd1, ALL_ONES, MIN_NEG, ALL_ONES};
        settle();
        // zero registers act as one
        apply_config(0, 0, 0);
        pending_values = '{64'd9, MIN_NEG};
        settle();

        set_idle(1);
        apply_config(RUN_MAX, 1, GROUP_MAX);
        queue_random(30);
        settle();
        set_idle(2);
        apply_config('1, 0, '1);
        queue_random(30);
        settle();
        // stride clamped to the line-store depth, low entries revisited
        set_idle(3);
        apply_config(2, '1, 1);
        queue_random(MAX_STRIDE + 6);
        settle();
        set_idle(0);

        // long output hold-off with a busy sender
        apply_config(4, 8, 10);
        hold_cycles = 400;
        queue_random(60);
        settle();

        phase = 0;
        while (random_items < 120)
        begin
            r = $urandom_range(4, 1);
            s = ($urandom_range(3) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
            g = $urandom_range(3, 1);
            tensor = r * s * g;
            n = (tensor > 48) ? tensor : tensor * $urandom_range(3, 1);
            if ($urandom_range(4) == 0)
            begin
                n = n + $urandom_range(tensor, 1) - 1;
            end
            set_idle(phase % 4);
            apply_config(RUN_WIDTH'(r), STRIDE_WIDTH'(s), GROUP_WIDTH'(g));
            queue_random(n);
            random_items = random_items + n;
            settle();
            phase = phase + 1;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_sums.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/scs_pkg.sv
rtl/scs_line_store.sv
rtl/strided_cumulative_sum_top.sv
test/tb.sv
